/* sv/dcc_fge_pkg.sv */
// Shared types and constants for the DCC function group encoder.
package dcc_fge_pkg;

   // Item kinds
   typedef enum logic [1:0] {
      KIND_ACTIVATE   = 2'd0,
      KIND_INACTIVATE = 2'd1,
      KIND_CLEAR      = 2'd2,
      KIND_SEND       = 2'd3
   } kind_type;

   // Function group instruction prefixes and extended opcodes
   localparam logic [7:0] GROUP1_BASE  = 8'd128;
   localparam logic [7:0] GROUP2_BASE  = 8'd176;
   localparam logic [7:0] GROUP3_BASE  = 8'd160;
   localparam logic [7:0] GROUP4_OP    = 8'd222;
   localparam logic [7:0] GROUP5_OP    = 8'd223;

   localparam int NUM_FLAGS    = 32;
   localparam int GROUP_FLAGS  = 29;  // F0..F28 belong to a group
   localparam int NUM_GROUPS   = 5;
   localparam int QUEUE_DEPTH  = 2;

   typedef struct packed {
      kind_type    kind;
      logic [4:0]  function_number;
      logic [7:0]  register_slot;
      logic [13:0] loco_address;
   } req_type;

   typedef struct packed {
      logic [7:0]  register_slot_res;
      logic [13:0] loco_address_res;
      logic [7:0]  instruction_byte;
      logic [7:0]  data_byte;
      logic        has_data_byte;
      logic        last;
   } rsp_type;

   // One send job handed from the front to the back
   typedef struct packed {
      logic [NUM_GROUPS-1:0]  changed;
      logic [GROUP_FLAGS-1:0] flags;
      logic [7:0]             register_slot;
      logic [13:0]            loco_address;
   } job_type;

endpackage

/* sv/dcc_function_group_encoder.sv */
// Top level of the DCC function group encoder: front end, job queue, emitter.
//
//  channel   ports                       transfer when
//  request   push, full, req_data        push && !full
//  response  empty, pop, rsp_data        pop && !empty
//
// Every item is handled in the front end; activate, inactivate and clear
// are done at acceptance. A send with n changed groups (0..5) gives n instructions
// in the emitter, one instruction per cycle while the output is empty or popped, with one output register.
// A two-entry job queue decouples the two; full rises only when it is full.
// Reset is synchronous and clears flags, queue and output valid; no sweep.
module dcc_function_group_encoder import dcc_fge_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic    job_push, job_full, job_pop, job_valid;
   job_type job_in, job_head;

   dcc_fge_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .job_push (job_push),
      .job_data (job_in),
      .job_full (job_full)
   );

   dcc_fge_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_en    (job_push),
      .push_job   (job_in),
      .full       (job_full),
      .pop_en     (job_pop),
      .head_valid (job_valid),
      .head_job   (job_head)
   );

   dcc_fge_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_head),
      .job_pop   (job_pop),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data)
   );

endmodule

/* sv/dcc_fge_front.sv */
// Front end: accepts items, keeps the function flags, builds send jobs.
module dcc_fge_front import dcc_fge_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   output logic    full,
   input  req_type req_data,
   output logic    job_push,
   output job_type job_data,
   input  logic    job_full
);

   logic [NUM_FLAGS-1:0] active_flags_ff, active_flags_in;
   logic [NUM_FLAGS-1:0] sent_flags_ff, sent_flags_in;
   logic [NUM_FLAGS-1:0] diff;
   logic                 accept;

   assign full   = job_full;
   assign accept = push && !full;
   assign diff   = active_flags_ff ^ sent_flags_ff;

   // Changed-group mask and job payload
   always_comb begin
      job_data.changed[0]    = |diff[4:0];
      job_data.changed[1]    = |diff[8:5];
      job_data.changed[2]    = |diff[12:9];
      job_data.changed[3]    = |diff[20:13];
      job_data.changed[4]    = |diff[28:21];
      job_data.flags         = active_flags_ff[GROUP_FLAGS-1:0];
      job_data.register_slot = req_data.register_slot;
      job_data.loco_address  = req_data.loco_address;
   end

   assign job_push = accept && (req_data.kind == KIND_SEND) && (job_data.changed != '0);

   // Flag updates per kind
   always_comb begin
      active_flags_in = active_flags_ff;
      sent_flags_in   = sent_flags_ff;
      if (accept) begin
         unique case (req_data.kind)
            KIND_ACTIVATE:   active_flags_in[req_data.function_number] = 1'b1;
            KIND_INACTIVATE: active_flags_in[req_data.function_number] = 1'b0;
            KIND_CLEAR: begin
               active_flags_in = '0;
               sent_flags_in   = '0;
            end
            KIND_SEND:       sent_flags_in = active_flags_ff;
            default:         active_flags_in = active_flags_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_flags_ff <= '0;
         sent_flags_ff   <= '0;
      end else begin
         active_flags_ff <= active_flags_in;
         sent_flags_ff   <= sent_flags_in;
      end
   end

`ifndef SYNTHESIS
   // a clear leaves both flag sets at zero
   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.kind == KIND_CLEAR |=> active_flags_ff == '0 && sent_flags_ff == '0)
      else $error("clear did not zero the flags");

   // after a send the sent copy matches what was active
   a_send_copies: assert property (@(posedge clock) disable iff (reset)
      accept && req_data.kind == KIND_SEND |=> sent_flags_ff == $past(active_flags_ff))
      else $error("send did not update sent copy");

   // jobs only come from sends
   a_job_from_send: assert property (@(posedge clock) disable iff (reset)
      job_push |-> req_data.kind == KIND_SEND && !job_full)
      else $error("job pushed by a non-send item");
`endif

endmodule

/* sv/dcc_fge_queue.sv */
// Two-entry job queue between the front end and the instruction emitter.
module dcc_fge_queue import dcc_fge_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_en,
   input  job_type push_job,
   output logic    full,
   input  logic    pop_en,
   output logic    head_valid,
   output job_type head_job
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_job   = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push_en && !(pop_en && head_valid)) count_in = count_ff + 1'b1;
      if (!push_en && pop_en && head_valid)   count_in = count_ff - 1'b1;
   end

   // Pointer and count update
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_en)               wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop_en && head_valid)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push_en) slot_ff[wr_ptr_ff] <= push_job;
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_en |-> !full)
      else $error("job queue overflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("job queue count out of range");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop_en |-> head_valid)
      else $error("job queue popped while empty");
`endif

endmodule

/* sv/dcc_fge_back.sv */
// Back end: walks the changed groups of each job, one instruction per cycle while the output is empty or popped.
module dcc_fge_back import dcc_fge_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    job_valid,
   input  job_type job_data,
   output logic    job_pop,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic [NUM_GROUPS-1:0] done_ff, done_in;
   logic [NUM_GROUPS-1:0] remaining, sel;
   logic                  out_valid_ff, out_valid_in;
   rsp_type               out_data_ff, next_rsp;
   logic                  emit, is_last;

   assign remaining = job_data.changed & ~done_ff;

   // Lowest pending group first
   always_comb begin
      sel = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (remaining[g]) sel = NUM_GROUPS'(1) << g;
      end
   end

   assign is_last = ((remaining & ~sel) == '0);
   assign emit    = job_valid && (!out_valid_ff || pop);
   assign job_pop = emit && is_last;

   // Instruction encoder for the selected group
   always_comb begin
      next_rsp.register_slot_res = job_data.register_slot;
      next_rsp.loco_address_res  = job_data.loco_address;
      next_rsp.last              = is_last;
      next_rsp.data_byte         = '0;
      next_rsp.has_data_byte     = 1'b0;
      next_rsp.instruction_byte  = GROUP1_BASE | {3'b000, job_data.flags[0], job_data.flags[4:1]};
      if (sel[1]) begin
         next_rsp.instruction_byte = GROUP2_BASE | {4'b0000, job_data.flags[8:5]};
      end else if (sel[2]) begin
         next_rsp.instruction_byte = GROUP3_BASE | {4'b0000, job_data.flags[12:9]};
      end else if (sel[3]) begin
         next_rsp.instruction_byte = GROUP4_OP;
         next_rsp.data_byte        = job_data.flags[20:13];
         next_rsp.has_data_byte    = 1'b1;
      end else if (sel[4]) begin
         next_rsp.instruction_byte = GROUP5_OP;
         next_rsp.data_byte        = job_data.flags[28:21];
         next_rsp.has_data_byte    = 1'b1;
      end
   end

   // Progress through the current job
   always_comb begin
      done_in = done_ff;
      if (emit) done_in = is_last ? '0 : (done_ff | sel);
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (emit)          out_valid_in = 1'b1;
      else if (pop)      out_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         done_ff      <= done_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) out_data_ff <= next_rsp;
   end

   assign empty    = !out_valid_ff;
   assign rsp_data = out_data_ff;

`ifndef SYNTHESIS
   a_job_nonempty: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> job_data.changed != '0)
      else $error("job with no changed group");

   a_done_subset: assert property (@(posedge clock) disable iff (reset)
      job_valid |-> (done_ff & ~job_data.changed) == '0)
      else $error("done mask outside changed groups");

   a_one_group: assert property (@(posedge clock) disable iff (reset)
      emit |-> $onehot(sel))
      else $error("emit without exactly one group selected");

   a_idle_done: assert property (@(posedge clock) disable iff (reset)
      !job_valid |-> done_ff == '0)
      else $error("progress left over with no job");
`endif

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the DCC function group encoder.
module testbench import dcc_fge_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    push = 1'b0;
   logic    full;
   req_type req_data = '0;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;

   // Predicted decoder state
   logic [31:0] flags_now = '0;
   logic [31:0] flags_sent = '0;
   rsp_type     pending_instructions[$];
   rsp_type     head_instruction;

   int error_count = 0;
   int push_idle_pct = 31;
   int pop_idle_pct = 31;

   dcc_function_group_encoder dut (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .req_data (req_data),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   task automatic flag_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   function automatic req_type build_command(input kind_type kind, input logic [4:0] fn,
                                             input logic [7:0] slot,
                                             input logic [13:0] addr);
      req_type cmd;
      cmd.kind            = kind;
      cmd.function_number = fn;
      cmd.register_slot   = slot;
      cmd.loco_address    = addr;
      return cmd;
   endfunction

   // Mostly legal addresses, now and then the full 14-bit range
   function automatic logic [13:0] draw_loco_address();
      if ($urandom_range(99) < 80) begin
         return 14'($urandom_range(10239));
      end
      return 14'($urandom_range(16383));
   endfunction

   // Update the flag model and queue the instructions a send produces
   task automatic encode_command(input req_type cmd);
      logic [31:0] changed;
      rsp_type     instr;
      rsp_type     batch[$];
      case (cmd.kind)
         KIND_ACTIVATE: begin
            flags_now[cmd.function_number] = 1'b1;
         end
         KIND_INACTIVATE: begin
            flags_now[cmd.function_number] = 1'b0;
         end
         KIND_CLEAR: begin
            flags_now  = '0;
            flags_sent = '0;
         end
         KIND_SEND: begin
            changed = flags_now ^ flags_sent;
            instr = '0;
            instr.register_slot_res = cmd.register_slot;
            instr.loco_address_res  = cmd.loco_address;
            // groups 1-3: prefix plus five (group 1) or four flags, no data byte
            if (|changed[4:0]) begin
               instr.instruction_byte = GROUP1_BASE + {3'b000, flags_now[0], flags_now[4:1]};
               batch.push_back(instr);
            end
            if (|changed[8:5]) begin
               instr.instruction_byte = GROUP2_BASE + {4'b0000, flags_now[8:5]};
               batch.push_back(instr);
            end
            if (|changed[12:9]) begin
               instr.instruction_byte = GROUP3_BASE + {4'b0000, flags_now[12:9]};
               batch.push_back(instr);
            end
            // groups 4-5: extended opcode plus a data byte
            instr.has_data_byte = 1'b1;
            if (|changed[20:13]) begin
               instr.instruction_byte = GROUP4_OP;
               instr.data_byte        = flags_now[20:13];
               batch.push_back(instr);
            end
            if (|changed[28:21]) begin
               instr.instruction_byte = GROUP5_OP;
               instr.data_byte        = flags_now[28:21];
               batch.push_back(instr);
            end
            if (batch.size() > 0) begin
               batch[batch.size()-1].last = 1'b1;
            end
            foreach (batch[i]) begin
               pending_instructions.push_back(batch[i]);
            end
            flags_sent = flags_now;
         end
         default: ;
      endcase
   endtask

   // Offer one command, with random idle cycles ahead of it, until transfer
   task automatic send_command(input req_type cmd);
      while ($urandom_range(99) < push_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= cmd;
      do @(posedge clock); while (full);
      encode_command(cmd);
   endtask

   // Check each instruction against the oldest prediction; pop at random
   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) begin
            if (pending_instructions.size() == 0) begin
               flag_mismatch($sformatf("unexpected instruction %0d",
                                       rsp_data.instruction_byte));
            end else begin
               head_instruction = pending_instructions.pop_front();
               if (rsp_data.register_slot_res !== head_instruction.register_slot_res)
                  flag_mismatch($sformatf("register_slot_res %0d, want %0d",
                     rsp_data.register_slot_res, head_instruction.register_slot_res));
               if (rsp_data.loco_address_res !== head_instruction.loco_address_res)
                  flag_mismatch($sformatf("loco_address_res %0d, want %0d",
                     rsp_data.loco_address_res, head_instruction.loco_address_res));
               if (rsp_data.instruction_byte !== head_instruction.instruction_byte)
                  flag_mismatch($sformatf("instruction_byte %0d, want %0d",
                     rsp_data.instruction_byte, head_instruction.instruction_byte));
               if (rsp_data.data_byte !== head_instruction.data_byte)
                  flag_mismatch($sformatf("data_byte %0d, want %0d",
                     rsp_data.data_byte, head_instruction.data_byte));
               if (rsp_data.has_data_byte !== head_instruction.has_data_byte)
                  flag_mismatch($sformatf("has_data_byte %0b, want %0b",
                     rsp_data.has_data_byte, head_instruction.has_data_byte));
               if (rsp_data.last !== head_instruction.last)
                  flag_mismatch($sformatf("last %0b, want %0b",
                     rsp_data.last, head_instruction.last));
            end
         end
         pop <= ($urandom_range(99) >= pop_idle_pct);
      end
   end

   // Group boundaries, address extremes, ungrouped flags, clear, repeat send
   task automatic test_directed();
      int group_edges[9] = '{4, 5, 8, 9, 12, 13, 20, 21, 28};
      send_command(build_command(KIND_SEND, 5'd0, 8'd1, 14'd3));
      send_command(build_command(KIND_ACTIVATE, 5'd0, 8'd0, 14'd0));
      send_command(build_command(KIND_SEND, 5'd0, 8'd0, 14'd0));
      foreach (group_edges[i]) begin
         send_command(build_command(KIND_ACTIVATE, 5'(group_edges[i]), 8'd0, 14'd0));
      end
      send_command(build_command(KIND_SEND, 5'd31, 8'd255, 14'd16383));
      // flags outside every group never produce an instruction
      send_command(build_command(KIND_ACTIVATE, 5'd29, 8'hff, 14'h3fff));
      send_command(build_command(KIND_ACTIVATE, 5'd31, 8'h00, 14'h0000));
      send_command(build_command(KIND_SEND, 5'd0, 8'd77, 14'd9000));
      send_command(build_command(KIND_INACTIVATE, 5'd28, 8'd0, 14'd0));
      send_command(build_command(KIND_SEND, 5'd0, 8'd128, 14'd10239));
      send_command(build_command(KIND_INACTIVATE, 5'd31, 8'd0, 14'd0));
      send_command(build_command(KIND_CLEAR, 5'd0, 8'd0, 14'd0));
      send_command(build_command(KIND_SEND, 5'd0, 8'd5, 14'd5));
      // second send of the same flags is silent
      send_command(build_command(KIND_ACTIVATE, 5'd3, 8'd0, 14'd0));
      send_command(build_command(KIND_SEND, 5'd0, 8'd42, 14'd8191));
      send_command(build_command(KIND_SEND, 5'd0, 8'd43, 14'd8192));
   endtask

   // Edit runs closed by a send, with some clears and random noise commands
   task automatic test_random_sequences(input int n_commands);
      int issued = 0;
      int n_edits;
      while (issued < n_commands) begin
         if ($urandom_range(99) < 10) begin
            send_command(build_command(kind_type'($urandom_range(3)), 5'($urandom_range(31)),
                                       8'($urandom_range(255)), draw_loco_address()));
            issued++;
         end else begin
            n_edits = $urandom_range(1, 6);
            repeat (n_edits) begin
               send_command(build_command(
                  ($urandom_range(99) < 60) ? KIND_ACTIVATE : KIND_INACTIVATE,
                  5'($urandom_range(31)), 8'($urandom_range(255)), draw_loco_address()));
            end
            issued += n_edits;
            if ($urandom_range(99) < 5) begin
               send_command(build_command(KIND_CLEAR, 5'($urandom_range(31)),
                                          8'($urandom_range(255)), draw_loco_address()));
               issued++;
            end
            send_command(build_command(KIND_SEND, 5'($urandom_range(31)),
                                       8'($urandom_range(255)), draw_loco_address()));
            issued++;
         end
      end
   endtask

   // Same traffic with both sides streaming, no idle cycles
   task automatic test_back_to_back(input int n_commands);
      push_idle_pct = 0;
      pop_idle_pct  = 0;
      test_random_sequences(n_commands);
      push_idle_pct = 31;
      pop_idle_pct  = 31;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_sequences(150);
      test_back_to_back(40);

      // drain, then leave room for any stray instruction
      push <= 1'b0;
      while (pending_instructions.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/dcc_fge_pkg.sv
sv/dcc_fge_front.sv
sv/dcc_fge_queue.sv
sv/dcc_fge_back.sv
sv/dcc_function_group_encoder.sv
verif/testbench.sv
